FILE: src/mcg_pkg.sv
`timescale 1ns / 1ps

package mcg_pkg;

	localparam int unsigned RADIUS_MAX_DEF = 63;
	localparam int unsigned COORD_MAX_DEF  = 4095;
	localparam int unsigned MAX_RESULTS    = 48;

	localparam int CC_W    = 12;
	localparam int R_W     = 6;
	localparam int COLOR_W = 24;
	localparam int OUT_W   = 14;
	localparam int X_W     = 8;
	localparam int Y_W     = 7;
	localparam int ACC_W   = 12;
	localparam int N_W     = 6;
	localparam int PC_W    = 2;

	localparam logic signed [ACC_W-1:0] DY_INIT    = -12'sd2;
	localparam logic signed [ACC_W-1:0] DELTA_STEP = 12'sd4;

	localparam logic [PC_W-1:0] PC_TAKE = 2'd0;
	localparam logic [PC_W-1:0] PC_AXIS = 2'd1;
	localparam logic [PC_W-1:0] PC_WALK = 2'd2;
	localparam logic [PC_W-1:0] PC_NONE = 2'd3;

	typedef struct packed {
		logic            wait_in;
		logic            wait_out;
		logic            load;
		logic            step;
		logic            emit;
		logic            axis;
		logic            jmp_done;
		logic [PC_W-1:0] nxt;
		logic [PC_W-1:0] tgt;
	} ctrl_word_t;

endpackage

FILE: src/mcg_rom.sv
`timescale 1ns / 1ps

module mcg_rom (
	input  logic [mcg_pkg::PC_W-1:0] pc,
	output mcg_pkg::ctrl_word_t      cw
);
	import mcg_pkg::*;

	always_comb begin
		cw = '0;
		case (pc)
			PC_TAKE: begin
				cw.wait_in = 1'b1;
				cw.load    = 1'b1;
				cw.nxt     = PC_AXIS;
				cw.tgt     = PC_AXIS;
			end
			PC_AXIS: begin
				cw.wait_out = 1'b1;
				cw.emit     = 1'b1;
				cw.axis     = 1'b1;
				cw.nxt      = PC_WALK;
				cw.tgt      = PC_WALK;
			end
			PC_WALK: begin
				cw.wait_out = 1'b1;
				cw.step     = 1'b1;
				cw.emit     = 1'b1;
				cw.jmp_done = 1'b1;
				cw.nxt      = PC_WALK;
				cw.tgt      = PC_TAKE;
			end
			default: begin
				cw.nxt = PC_TAKE;
				cw.tgt = PC_TAKE;
			end
		endcase
	end

endmodule

FILE: src/mcg_datapath.sv
`timescale 1ns / 1ps

module mcg_datapath #(
	parameter int unsigned RADIUS_MAX = mcg_pkg::RADIUS_MAX_DEF,
	parameter int unsigned COORD_MAX  = mcg_pkg::COORD_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcg_pkg::ctrl_word_t               cw,
	input  logic                              adv,
	input  logic [mcg_pkg::CC_W-1:0]          center_col,
	input  logic [mcg_pkg::CC_W-1:0]          center_row,
	input  logic [mcg_pkg::R_W-1:0]           radius,
	input  logic [mcg_pkg::COLOR_W-1:0]       color,
	input  logic                              out_ready,
	output logic                              out_free,
	output logic                              done,
	output logic                              out_valid,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_plus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_minus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_plus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_minus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_plus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_minus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_plus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_minus_x,
	output logic [mcg_pkg::COLOR_W-1:0]       pixel_color,
	output logic                              axis_step,
	output logic                              last
);
	import mcg_pkg::*;

	logic [CC_W-1:0]         cc_q, cr_q, cc_sat, cr_sat;
	logic [R_W-1:0]          r_sat;
	logic [COLOR_W-1:0]      color_q;
	logic signed [X_W-1:0]   x_q, x_nx, ex;
	logic [Y_W-1:0]          y_q, y_nx, ey;
	logic signed [ACC_W-1:0] d_q, dy_q, dx_q, d_sum, d_nx, dx_nx;
	logic [N_W-1:0]          n_q;
	logic                    neg, load_en, step_en, emit_en, out_valid_q;
	logic [OUT_W-1:0]        ccx, crx, exx, eyx;

	assign cc_sat = ({4'b0, center_col} > COORD_MAX[15:0]) ? COORD_MAX[CC_W-1:0] : center_col;
	assign cr_sat = ({4'b0, center_row} > COORD_MAX[15:0]) ? COORD_MAX[CC_W-1:0] : center_row;
	assign r_sat  = (radius > RADIUS_MAX[R_W-1:0]) ? RADIUS_MAX[R_W-1:0] : radius;

	assign load_en = cw.load & adv;
	assign step_en = cw.step & adv;
	assign emit_en = cw.emit & adv;

	assign d_sum = d_q + dy_q;
	assign neg   = d_sum[ACC_W-1];
	assign d_nx  = neg ? d_sum + dx_q : d_sum;
	assign dx_nx = neg ? dx_q - DELTA_STEP : dx_q;
	assign x_nx  = neg ? x_q - 8'sd1 : x_q;
	assign y_nx  = y_q + 7'd1;

	assign ex = cw.step ? x_nx : x_q;
	assign ey = cw.step ? y_nx : y_q;

	assign done = cw.step & (($signed({2'b00, y_nx}) > $signed({x_nx[X_W-1], x_nx}))
		| (({1'b0, n_q} + 7'd1) >= 7'(MAX_RESULTS)));

	always_ff @(posedge clk) begin
		if (load_en) begin
			cc_q    <= cc_sat;
			cr_q    <= cr_sat;
			color_q <= color;
			x_q     <= {2'b00, r_sat};
			y_q     <= '0;
			d_q     <= {5'b0, r_sat, 1'b0} - 12'sd1;
			dy_q    <= DY_INIT;
			dx_q    <= {4'b0, r_sat, 2'b0} - DELTA_STEP;
			n_q     <= '0;
		end else begin
			if (step_en) begin
				x_q  <= x_nx;
				y_q  <= y_nx;
				d_q  <= d_nx;
				dy_q <= dy_q - DELTA_STEP;
				dx_q <= dx_nx;
			end
			if (emit_en) begin
				n_q <= n_q + 6'd1;
			end
		end
	end

	assign ccx = {2'b00, cc_q};
	assign crx = {2'b00, cr_q};
	assign exx = {{(OUT_W-X_W){ex[X_W-1]}}, ex};
	assign eyx = {{(OUT_W-Y_W){1'b0}}, ey};

	always_ff @(posedge clk) begin
		if (emit_en) begin
			col_plus_x  <= ccx + exx;
			col_minus_x <= ccx - exx;
			row_plus_y  <= crx + eyx;
			row_minus_y <= crx - eyx;
			col_plus_y  <= ccx + eyx;
			col_minus_y <= ccx - eyx;
			row_plus_x  <= crx + exx;
			row_minus_x <= crx - exx;
			pixel_color <= color_q;
			axis_step   <= cw.axis;
			last        <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

endmodule

FILE: src/midpoint_circle_generator_unit.sv
`timescale 1ns / 1ps
// Channel  Handshake            Word
// in       in_valid/in_ready    center_col, center_row, radius, color
// out      out_valid/out_ready  eight coordinates, pixel_color, axis_step, last
//
// The command is taken first, then one result word leaves per cycle while the output
// is not stalled: floor(r/sqrt(2)) + 2 or + 3 words per circle, 48 words at most.
// The figure is set by the control store stepping once per word.
// Reset clears the sequencer program counter and the output valid flag only.
// A stalled output register holds the sequencer in place.

module midpoint_circle_generator_unit #(
	parameter int unsigned RADIUS_MAX = mcg_pkg::RADIUS_MAX_DEF,
	parameter int unsigned COORD_MAX  = mcg_pkg::COORD_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mcg_pkg::CC_W-1:0]          center_col,
	input  logic [mcg_pkg::CC_W-1:0]          center_row,
	input  logic [mcg_pkg::R_W-1:0]           radius,
	input  logic [mcg_pkg::COLOR_W-1:0]       color,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_plus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_minus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_plus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_minus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_plus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  col_minus_y,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_plus_x,
	output logic signed [mcg_pkg::OUT_W-1:0]  row_minus_x,
	output logic [mcg_pkg::COLOR_W-1:0]       pixel_color,
	output logic                              axis_step,
	output logic                              last
);
	import mcg_pkg::*;

	logic [PC_W-1:0] pc_q;
	ctrl_word_t      cw;
	logic            adv, out_free, done;

	mcg_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	assign adv      = (~cw.wait_in | in_valid) & (~cw.wait_out | out_free);
	assign in_ready = cw.wait_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_TAKE;
		end else if (adv) begin
			pc_q <= (cw.jmp_done & done) ? cw.tgt : cw.nxt;
		end
	end

	mcg_datapath #(
		.RADIUS_MAX (RADIUS_MAX),
		.COORD_MAX  (COORD_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cw          (cw),
		.adv         (adv),
		.center_col  (center_col),
		.center_row  (center_row),
		.radius      (radius),
		.color       (color),
		.out_ready   (out_ready),
		.out_free    (out_free),
		.done        (done),
		.out_valid   (out_valid),
		.col_plus_x  (col_plus_x),
		.col_minus_x (col_minus_x),
		.row_plus_y  (row_plus_y),
		.row_minus_y (row_minus_y),
		.col_plus_y  (col_plus_y),
		.col_minus_y (col_minus_y),
		.row_plus_x  (row_plus_x),
		.row_minus_x (row_minus_x),
		.pixel_color (pixel_color),
		.axis_step   (axis_step),
		.last        (last)
	);

endmodule

FILE: src/mcg_checker.sv
`timescale 1ns / 1ps

module mcg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [mcg_pkg::OUT_W-1:0]  col_plus_x,
	input logic signed [mcg_pkg::OUT_W-1:0]  row_plus_y,
	input logic signed [mcg_pkg::OUT_W-1:0]  row_minus_y,
	input logic signed [mcg_pkg::OUT_W-1:0]  col_plus_y,
	input logic signed [mcg_pkg::OUT_W-1:0]  col_minus_y,
	input logic                              axis_step,
	input logic                              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(col_plus_x) && $stable(last))
		else $error("output word changed while stalled");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while previous circle starts");

	a_axis_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_step |-> !last)
		else $error("axis word marked last");

	a_axis_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_step |-> row_plus_y == row_minus_y && col_plus_y == col_minus_y)
		else $error("axis word with nonzero y offset");

endmodule

bind midpoint_circle_generator_unit mcg_checker u_mcg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.col_plus_x  (col_plus_x),
	.row_plus_y  (row_plus_y),
	.row_minus_y (row_minus_y),
	.col_plus_y  (col_plus_y),
	.col_minus_y (col_minus_y),
	.axis_step   (axis_step),
	.last        (last)
);

FILE: sim/tb_midpoint_circle_generator_unit.sv
`timescale 1ns / 1ps

module tb_midpoint_circle_generator_unit;
	import mcg_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [OUT_W-1:0]   col_plus_x;
		logic [OUT_W-1:0]   col_minus_x;
		logic [OUT_W-1:0]   row_plus_y;
		logic [OUT_W-1:0]   row_minus_y;
		logic [OUT_W-1:0]   col_plus_y;
		logic [OUT_W-1:0]   col_minus_y;
		logic [OUT_W-1:0]   row_plus_x;
		logic [OUT_W-1:0]   row_minus_x;
		logic [COLOR_W-1:0] pixel_color;
		logic               axis_step;
		logic               last;
	} pixel_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [CC_W-1:0]           center_col;
	logic [CC_W-1:0]           center_row;
	logic [R_W-1:0]            radius;
	logic [COLOR_W-1:0]        color;
	logic                      out_valid;
	logic                      out_ready;
	logic [OUT_W-1:0]          col_plus_x;
	logic [OUT_W-1:0]          col_minus_x;
	logic [OUT_W-1:0]          row_plus_y;
	logic [OUT_W-1:0]          row_minus_y;
	logic [OUT_W-1:0]          col_plus_y;
	logic [OUT_W-1:0]          col_minus_y;
	logic [OUT_W-1:0]          row_plus_x;
	logic [OUT_W-1:0]          row_minus_x;
	logic [COLOR_W-1:0]        pixel_color;
	logic                      axis_step;
	logic                      last;

	pixel_word_t pending_pixels[$];
	int          errors;
	int          quiet_cycles;
	bit          no_idle;

	midpoint_circle_generator_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.center_col  (center_col),
		.center_row  (center_row),
		.radius      (radius),
		.color       (color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.col_plus_x  (col_plus_x),
		.col_minus_x (col_minus_x),
		.row_plus_y  (row_plus_y),
		.row_minus_y (row_minus_y),
		.col_plus_y  (col_plus_y),
		.col_minus_y (col_minus_y),
		.row_plus_x  (row_plus_x),
		.row_minus_x (row_minus_x),
		.pixel_color (pixel_color),
		.axis_step   (axis_step),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void push_pixel(int cc, int cr, int x, int y, logic [COLOR_W-1:0] rgb,
			bit axis, bit fin);
		pixel_word_t w;
		w.col_plus_x  = OUT_W'(cc + x);
		w.col_minus_x = OUT_W'(cc - x);
		w.row_plus_y  = OUT_W'(cr + y);
		w.row_minus_y = OUT_W'(cr - y);
		w.col_plus_y  = OUT_W'(cc + y);
		w.col_minus_y = OUT_W'(cc - y);
		w.row_plus_x  = OUT_W'(cr + x);
		w.row_minus_x = OUT_W'(cr - x);
		w.pixel_color = rgb;
		w.axis_step   = axis;
		w.last        = fin;
		pending_pixels.push_back(w);
	endfunction

	function automatic void plot_circle(logic [CC_W-1:0] cc_in, logic [CC_W-1:0] cr_in,
			logic [R_W-1:0] r_in, logic [COLOR_W-1:0] rgb);
		int cc, cr, r, x, y, d, dy, dx, n;
		bit done;
		cc = (cc_in > COORD_MAX_DEF) ? int'(COORD_MAX_DEF) : int'(cc_in);
		cr = (cr_in > COORD_MAX_DEF) ? int'(COORD_MAX_DEF) : int'(cr_in);
		r  = (r_in > RADIUS_MAX_DEF) ? int'(RADIUS_MAX_DEF) : int'(r_in);
		x  = r;
		y  = 0;
		d  = 2 * r - 1;
		dy = -2;
		dx = 4 * r - 4;
		push_pixel(cc, cr, x, y, rgb, 1'b1, 1'b0);
		n = 1;
		done = 1'b0;
		while (!done) begin
			d  += dy;
			dy -= 4;
			y  += 1;
			if (d < 0) begin
				d  += dx;
				dx -= 4;
				x  -= 1;
			end
			done = (y > x) || (n + 1 >= int'(MAX_RESULTS));
			push_pixel(cc, cr, x, y, rgb, 1'b0, done);
			n += 1;
		end
	endfunction

	task automatic send_circle(logic [CC_W-1:0] cc, logic [CC_W-1:0] cr, logic [R_W-1:0] r,
			logic [COLOR_W-1:0] rgb);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 32) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		center_col = cc;
		center_row = cr;
		radius     = r;
		color      = rgb;
		in_valid   = 1'b1;
		do @(posedge clk); while (!in_ready);
		plot_circle(cc, cr, r, rgb);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s expected %h actual %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t ns: word with none expected, expected none actual %h %h",
					$realtime, col_plus_x, row_plus_y);
			end else begin
				want = pending_pixels.pop_front();
				check_field("col_plus_x",  want.col_plus_x,  col_plus_x);
				check_field("col_minus_x", want.col_minus_x, col_minus_x);
				check_field("row_plus_y",  want.row_plus_y,  row_plus_y);
				check_field("row_minus_y", want.row_minus_y, row_minus_y);
				check_field("col_plus_y",  want.col_plus_y,  col_plus_y);
				check_field("col_minus_y", want.col_minus_y, col_minus_y);
				check_field("row_plus_x",  want.row_plus_x,  row_plus_x);
				check_field("row_minus_x", want.row_minus_x, row_minus_x);
				check_field("pixel_color", want.pixel_color, pixel_color);
				check_field("axis_step",   want.axis_step,   axis_step);
				check_field("last",        want.last,        last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = no_idle || ($urandom_range(99) >= 32);
		end
	end

	task automatic test_small_radii();
		send_circle(12'd100, 12'd200, 6'd0, 24'h123456);
		send_circle(12'd100, 12'd200, 6'd1, 24'h654321);
		send_circle(12'd300, 12'd40, 6'd2, 24'h00FF00);
		send_circle(12'd2048, 12'd2048, 6'd3, 24'hFF0000);
		send_circle(12'd0, 12'd0, 6'd0, 24'h0000FF);
		send_circle(12'd4095, 12'd4095, 6'd0, 24'hFFFFFF);
	endtask

	task automatic test_edges();
		send_circle(12'd0, 12'd0, 6'd63, 24'h000000);
		send_circle(12'd4095, 12'd4095, 6'd63, 24'hFFFFFF);
		send_circle(12'd0, 12'd4095, 6'd63, 24'hAAAAAA);
		send_circle(12'd4095, 12'd0, 6'd45, 24'h555555);
		send_circle(12'd10, 12'd4090, 6'd62, 24'h800001);
		send_circle(12'd2730, 12'd1365, 6'd42, 24'h7FFFFE);
		send_circle(12'd1365, 12'd2730, 6'd21, 24'hC3C3C3);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (40)
			send_circle(12'($urandom), 12'($urandom), 6'($urandom_range(0, 12)), 24'($urandom));
		no_idle = 1'b0;
	endtask

	task automatic test_random_circles();
		logic [CC_W-1:0] cc, cr;
		logic [R_W-1:0]  r;
		repeat (447) begin
			case ($urandom_range(3))
				0: cc = 12'($urandom_range(0, 63));
				1: cc = 12'($urandom_range(4032, 4095));
				default: cc = 12'($urandom);
			endcase
			case ($urandom_range(3))
				0: cr = 12'($urandom_range(0, 63));
				1: cr = 12'($urandom_range(4032, 4095));
				default: cr = 12'($urandom);
			endcase
			r = ($urandom_range(1) != 0) ? 6'($urandom_range(0, 8)) : 6'($urandom);
			send_circle(cc, cr, r, 24'($urandom));
		end
	endtask

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		no_idle      = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		center_col   = '0;
		center_row   = '0;
		radius       = '0;
		color        = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_small_radii();
		test_edges();
		test_back_to_back();
		test_random_circles();

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/mcg_pkg.sv
src/mcg_rom.sv
src/mcg_datapath.sv
src/midpoint_circle_generator_unit.sv
src/mcg_checker.sv
sim/tb_midpoint_circle_generator_unit.sv
